[design/bwt_pkg.sv]
// shared constants, types and helpers for the packet block window tracker
// no dependencies; every other design file refers to this package by scope
package bwt_pkg;

  // ring geometry (both must stay powers of two)
  localparam int BASELINES = 256;
  localparam int NBLOCKS   = 4;
  localparam int SLOT_W    = $clog2(BASELINES);
  localparam int BLK_W     = $clog2(NBLOCKS);
  localparam int ADDR_W    = SLOT_W + BLK_W;
  localparam int DEPTH     = NBLOCKS * BASELINES;

  // field and counter widths
  localparam int BCNT_W = 32;
  localparam int CNT_W  = 24;
  localparam int SUM_W  = 32;
  localparam int DROP_W = 16;
  localparam int TAG_W  = 32;
  localparam int OBLK_W = 2;
  localparam int OSLOT_W = 8;

  // window limits, in baseline counts from the window start
  localparam logic [BCNT_W-1:0] SPAN_RETIRE = BCNT_W'(2 * BASELINES);
  localparam logic [BCNT_W-1:0] SPAN_WINDOW = BCNT_W'(3 * BASELINES);
  localparam logic [BCNT_W-1:0] BLOCK_STEP  = BCNT_W'(BASELINES);

  localparam logic [CNT_W-1:0] EXPECTED_RESET = CNT_W'(4096);

  // write request into the slot tag store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag;
  } tag_wr_t;

  // one result beat
  typedef struct packed {
    logic               accepted;
    logic [OBLK_W-1:0]  block_index;
    logic [OSLOT_W-1:0] baseline_slot;
    logic               first_in_slot;
    logic               block_filled;
    logic [OBLK_W-1:0]  filled_block_index;
    logic [BCNT_W-1:0]  filled_start_count;
    logic [CNT_W-1:0]   filled_missed;
    logic [SUM_W-1:0]   missed_total;
    logic [DROP_W-1:0]  drop_count;
  } result_t;

  // flat slot address: block * BASELINES + slot
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BCNT_W-1:0] bcnt);
    return bcnt[ADDR_W-1:0];
  endfunction

endpackage

[design/bwt_slot_tags.sv]
// slot tag store: one epoch tag per (block, slot), registered read with write bypass
// clears itself after reset in one pass over all DEPTH entries; uses bwt_pkg
module bwt_slot_tags (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [bwt_pkg::ADDR_W-1:0]  rd_addr,
  input  bwt_pkg::tag_wr_t            wr,
  output logic [bwt_pkg::TAG_W-1:0]   rd_tag,
  output logic                        busy
);

  logic [bwt_pkg::TAG_W-1:0]  mem [bwt_pkg::DEPTH];
  logic [bwt_pkg::TAG_W-1:0]  rd_q_r;
  logic                       byp_r;
  logic [bwt_pkg::TAG_W-1:0]  byp_tag_r;
  logic                       busy_r;
  logic [bwt_pkg::ADDR_W-1:0] clr_addr_r;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == bwt_pkg::ADDR_W'(bwt_pkg::DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // single write port, shared by the clearing pass
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.tag;
    end
  end

  // registered read; a write to the same entry on the same edge wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      byp_r     <= wr.en && (wr.addr == rd_addr);
      byp_tag_r <= wr.tag;
    end
  end

  assign rd_tag = byp_r ? byp_tag_r : rd_q_r;
  assign busy   = busy_r;

endmodule

[design/bwt_window.sv]
// window state and per-packet update: retirement, counts, epochs, drop and missed totals
// uses bwt_pkg; the slot tag for the packet comes from bwt_slot_tags
module bwt_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        proc,
  input  logic [bwt_pkg::BCNT_W-1:0]  bcnt,
  input  logic [bwt_pkg::TAG_W-1:0]   tag,
  input  logic                        cfg_we,
  input  logic [bwt_pkg::CNT_W-1:0]   cfg_data,
  output bwt_pkg::result_t            res,
  output bwt_pkg::tag_wr_t            wr
);

  logic                        started_r;
  logic [bwt_pkg::BCNT_W-1:0]  window_start_r, window_start_nxt;
  logic [bwt_pkg::BLK_W-1:0]   current_block_r, current_block_nxt;
  logic [bwt_pkg::CNT_W-1:0]   counts_r [bwt_pkg::NBLOCKS];
  logic [bwt_pkg::CNT_W-1:0]   counts_nxt [bwt_pkg::NBLOCKS];
  logic [bwt_pkg::TAG_W-1:0]   epoch_r [bwt_pkg::NBLOCKS];
  logic [bwt_pkg::TAG_W-1:0]   epoch_nxt [bwt_pkg::NBLOCKS];
  logic [bwt_pkg::SUM_W-1:0]   missed_sum_r, missed_sum_nxt;
  logic [bwt_pkg::DROP_W-1:0]  dropped_r, dropped_nxt;
  logic [bwt_pkg::CNT_W-1:0]   expected_r;

  logic [bwt_pkg::BLK_W-1:0]   blk, cb;
  logic [bwt_pkg::SLOT_W-1:0]  slot;
  logic [bwt_pkg::BCNT_W-1:0]  ws, offs;
  logic                        acc, ret, blk_clr, first;
  logic [bwt_pkg::CNT_W-1:0]   cnt_cur, miss;
  logic [bwt_pkg::TAG_W-1:0]   ep_blk, ep_eff;
  logic [bwt_pkg::SUM_W:0]     sum_ext;
  logic [bwt_pkg::DROP_W-1:0]  drop_base;

  // decode packet and window position
  always_comb begin
    blk  = bcnt[bwt_pkg::ADDR_W-1:bwt_pkg::SLOT_W];
    slot = bcnt[bwt_pkg::SLOT_W-1:0];
    ws   = started_r ? window_start_r : bcnt;
    cb   = started_r ? current_block_r : blk;
    offs = bcnt - ws;
    acc  = offs < bwt_pkg::SPAN_WINDOW;
    ret  = acc && (offs >= bwt_pkg::SPAN_RETIRE);
  end

  // lane select of the retiring block count and the packet block epoch
  always_comb begin
    cnt_cur = '0;
    ep_blk  = '0;
    for (int b = 0; b < bwt_pkg::NBLOCKS; b++) begin
      if (bwt_pkg::BLK_W'(b) == cb) cnt_cur = counts_r[b];
      if (bwt_pkg::BLK_W'(b) == blk) ep_blk = epoch_r[b];
    end
  end

  // missed packets of the retiring block, saturating total
  always_comb begin
    miss    = (expected_r > cnt_cur) ? expected_r - cnt_cur : '0;
    sum_ext = {1'b0, missed_sum_r} + {{(bwt_pkg::SUM_W + 1 - bwt_pkg::CNT_W){1'b0}}, miss};
    if (ret) begin
      missed_sum_nxt = sum_ext[bwt_pkg::SUM_W] ? '1 : sum_ext[bwt_pkg::SUM_W-1:0];
    end else begin
      missed_sum_nxt = missed_sum_r;
    end
  end

  // first-of-slot check against the block epoch after any clear
  always_comb begin
    blk_clr = !started_r || (ret && (blk == cb));
    ep_eff  = ep_blk + bwt_pkg::TAG_W'(blk_clr);
    first   = acc && (tag != ep_eff);
  end

  // per-lane count and epoch update
  always_comb begin
    logic                      lane_clr;
    logic [bwt_pkg::CNT_W-1:0] base;
    for (int b = 0; b < bwt_pkg::NBLOCKS; b++) begin
      lane_clr = !started_r || (ret && (bwt_pkg::BLK_W'(b) == cb));
      base     = lane_clr ? '0 : counts_r[b];
      if (acc && (bwt_pkg::BLK_W'(b) == blk) && (base != '1)) begin
        counts_nxt[b] = base + 1'b1;
      end else begin
        counts_nxt[b] = base;
      end
      epoch_nxt[b] = epoch_r[b] + bwt_pkg::TAG_W'(lane_clr);
    end
  end

  // drop counter and window advance
  always_comb begin
    drop_base         = (!started_r || ret) ? '0 : dropped_r;
    dropped_nxt       = (!acc && (drop_base != '1)) ? drop_base + 1'b1 : drop_base;
    window_start_nxt  = ret ? ws + bwt_pkg::BLOCK_STEP : ws;
    current_block_nxt = ret ? cb + 1'b1 : cb;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r       <= 1'b0;
      window_start_r  <= '0;
      current_block_r <= '0;
      missed_sum_r    <= '0;
      dropped_r       <= '0;
      expected_r      <= bwt_pkg::EXPECTED_RESET;
      for (int b = 0; b < bwt_pkg::NBLOCKS; b++) begin
        counts_r[b] <= '0;
        epoch_r[b]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        expected_r <= cfg_data;
      end
      if (proc) begin
        started_r       <= 1'b1;
        window_start_r  <= window_start_nxt;
        current_block_r <= current_block_nxt;
        missed_sum_r    <= missed_sum_nxt;
        dropped_r       <= dropped_nxt;
        for (int b = 0; b < bwt_pkg::NBLOCKS; b++) begin
          counts_r[b] <= counts_nxt[b];
          epoch_r[b]  <= epoch_nxt[b];
        end
      end
    end
  end

  // tag write marks the slot as seen in the current epoch
  always_comb begin
    wr.en   = proc && first;
    wr.addr = bwt_pkg::slot_addr(bcnt);
    wr.tag  = ep_eff;
  end

  // result beat
  always_comb begin
    res.accepted           = acc;
    res.block_index        = bwt_pkg::OBLK_W'(blk);
    res.baseline_slot      = bwt_pkg::OSLOT_W'(slot);
    res.first_in_slot      = first;
    res.block_filled       = ret;
    res.filled_block_index = ret ? bwt_pkg::OBLK_W'(cb) : '0;
    res.filled_start_count = ret ? ws : '0;
    res.filled_missed      = ret ? miss : '0;
    res.missed_total       = missed_sum_nxt;
    res.drop_count         = dropped_nxt;
  end

endmodule

[design/packet_block_window_tracker_core.sv]
// top level of the packet block window tracker: input register, update logic, result register
// uses bwt_pkg, bwt_slot_tags and bwt_window
// path: an accepted beat waits in the input register, then its result goes to the result register
// throughput: one packet per cycle; a held result keeps the input register full and stalls input
// reset: synchronous, active low; afterwards the tag store clears all of its DEPTH entries,
// during which in_stall stays high (configuration writes are still taken)
module packet_block_window_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bwt_pkg::BCNT_W-1:0]    in_packet_bcnt,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [bwt_pkg::OBLK_W-1:0]    out_block_index,
  output logic [bwt_pkg::OSLOT_W-1:0]   out_baseline_slot,
  output logic                          out_first_in_slot,
  output logic                          out_block_filled,
  output logic [bwt_pkg::OBLK_W-1:0]    out_filled_block_index,
  output logic [bwt_pkg::BCNT_W-1:0]    out_filled_start_count,
  output logic [bwt_pkg::CNT_W-1:0]     out_filled_missed,
  output logic [bwt_pkg::SUM_W-1:0]     out_missed_total,
  output logic [bwt_pkg::DROP_W-1:0]    out_drop_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bwt_pkg::CNT_W-1:0]     cfg_expected_packets
);

  logic                        in_valid_r, in_valid_nxt;
  logic [bwt_pkg::BCNT_W-1:0]  in_bcnt_r;
  logic                        out_valid_r, out_valid_nxt;
  bwt_pkg::result_t            res_r;
  bwt_pkg::result_t            res;
  bwt_pkg::tag_wr_t            tag_wr;
  logic [bwt_pkg::TAG_W-1:0]   tag;
  logic                        busy, res_free, proc, in_acc;

  // handshake between the two register stages
  always_comb begin
    res_free      = !out_valid_r || !out_stall;
    proc          = in_valid_r && res_free;
    in_stall      = busy || (in_valid_r && !res_free);
    in_acc        = in_valid && !in_stall;
    in_valid_nxt  = in_acc || (in_valid_r && !proc);
    out_valid_nxt = proc || (out_valid_r && out_stall);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_bcnt_r <= in_packet_bcnt;
    end
  end

  // slot tag lookup runs alongside the input register
  bwt_slot_tags u_tags (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (bwt_pkg::slot_addr(in_packet_bcnt)),
    .wr      (tag_wr),
    .rd_tag  (tag),
    .busy    (busy)
  );

  bwt_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .bcnt     (in_bcnt_r),
    .tag      (tag),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_expected_packets),
    .res      (res),
    .wr       (tag_wr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res;
    end
  end

  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_accepted           = res_r.accepted;
  assign out_block_index        = res_r.block_index;
  assign out_baseline_slot      = res_r.baseline_slot;
  assign out_first_in_slot      = res_r.first_in_slot;
  assign out_block_filled       = res_r.block_filled;
  assign out_filled_block_index = res_r.filled_block_index;
  assign out_filled_start_count = res_r.filled_start_count;
  assign out_filled_missed      = res_r.filled_missed;
  assign out_missed_total       = res_r.missed_total;
  assign out_drop_count         = res_r.drop_count;

endmodule

[verif/packet_block_window_tracker_core_tb.sv]
// testbench for packet_block_window_tracker_core: beats checked against an in-bench window model
// needs bwt_pkg and the core; directed opening rows, random traffic, out-of-window burst
`timescale 1ns / 1ps

module packet_block_window_tracker_core_tb;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DROP_BURST  = 40;

  typedef struct {
    logic [bwt_pkg::BCNT_W-1:0] bcnt;
    bit                         typed;
    bwt_pkg::result_t           res;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [bwt_pkg::BCNT_W-1:0] in_packet_bcnt;
  logic out_valid;
  logic out_stall;
  logic out_accepted;
  logic [bwt_pkg::OBLK_W-1:0] out_block_index;
  logic [bwt_pkg::OSLOT_W-1:0] out_baseline_slot;
  logic out_first_in_slot;
  logic out_block_filled;
  logic [bwt_pkg::OBLK_W-1:0] out_filled_block_index;
  logic [bwt_pkg::BCNT_W-1:0] out_filled_start_count;
  logic [bwt_pkg::CNT_W-1:0] out_filled_missed;
  logic [bwt_pkg::SUM_W-1:0] out_missed_total;
  logic [bwt_pkg::DROP_W-1:0] out_drop_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [bwt_pkg::CNT_W-1:0] cfg_expected_packets;

  // window model state
  bit                         trk_started;
  logic [bwt_pkg::BCNT_W-1:0] trk_start;
  int unsigned                trk_block;
  logic [bwt_pkg::CNT_W-1:0]  trk_counts [bwt_pkg::NBLOCKS];
  bit                         trk_seen [bwt_pkg::DEPTH];
  logic [bwt_pkg::SUM_W-1:0]  trk_missed = '0;
  logic [bwt_pkg::DROP_W-1:0] trk_drops;
  logic [bwt_pkg::CNT_W-1:0]  cur_expected = bwt_pkg::EXPECTED_RESET;

  bwt_pkg::result_t pending_reports [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;
  int unsigned stall_left = 0;
  opening_row_t opening_rows [18];

  packet_block_window_tracker_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_packet_bcnt         (in_packet_bcnt),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_accepted           (out_accepted),
    .out_block_index        (out_block_index),
    .out_baseline_slot      (out_baseline_slot),
    .out_first_in_slot      (out_first_in_slot),
    .out_block_filled       (out_block_filled),
    .out_filled_block_index (out_filled_block_index),
    .out_filled_start_count (out_filled_start_count),
    .out_filled_missed      (out_filled_missed),
    .out_missed_total       (out_missed_total),
    .out_drop_count         (out_drop_count),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_expected_packets   (cfg_expected_packets)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("packet_block_window_tracker_core_tb failed");
      $finish;
    end
  end

  task automatic clear_block(input int unsigned blk);
    int unsigned s;
    trk_counts[blk] = '0;
    for (s = 0; s < bwt_pkg::BASELINES; s++) trk_seen[blk * bwt_pkg::BASELINES + s] = 1'b0;
  endtask

  // window model: one report per packet header
  task automatic track_window(input logic [bwt_pkg::BCNT_W-1:0] bcnt,
                              output bwt_pkg::result_t rep);
    int unsigned blk;
    int unsigned slot;
    int unsigned b;
    int unsigned k;
    logic [bwt_pkg::BCNT_W-1:0] span;
    logic [bwt_pkg::CNT_W-1:0] cnt;
    logic [bwt_pkg::CNT_W-1:0] miss;
    logic [bwt_pkg::SUM_W:0] sum;
    blk = (bcnt / bwt_pkg::BASELINES) % bwt_pkg::NBLOCKS;
    slot = bcnt % bwt_pkg::BASELINES;
    rep = '0;
    rep.block_index = bwt_pkg::OBLK_W'(blk);
    rep.baseline_slot = bwt_pkg::OSLOT_W'(slot);
    // first header after reset opens the window
    if (!trk_started) begin
      for (b = 0; b < bwt_pkg::NBLOCKS; b++) clear_block(b);
      trk_start = bcnt;
      trk_block = blk;
      trk_drops = '0;
      trk_started = 1'b1;
    end
    span = bcnt - trk_start;
    if (span < bwt_pkg::SPAN_WINDOW) begin
      rep.accepted = 1'b1;
      // two blocks ahead: retire the oldest block
      if (span >= bwt_pkg::SPAN_RETIRE) begin
        cnt = trk_counts[trk_block];
        miss = (cur_expected > cnt) ? cur_expected - cnt : '0;
        sum = {1'b0, trk_missed} + miss;
        trk_missed = sum[bwt_pkg::SUM_W] ? '1 : sum[bwt_pkg::SUM_W-1:0];
        rep.block_filled = 1'b1;
        rep.filled_block_index = bwt_pkg::OBLK_W'(trk_block);
        rep.filled_start_count = trk_start;
        rep.filled_missed = miss;
        clear_block(trk_block);
        trk_start = trk_start + bwt_pkg::BLOCK_STEP;
        trk_block = (trk_block + 1) % bwt_pkg::NBLOCKS;
        trk_drops = '0;
      end
      k = blk * bwt_pkg::BASELINES + slot;
      if (!trk_seen[k]) begin
        trk_seen[k] = 1'b1;
        rep.first_in_slot = 1'b1;
      end
      if (trk_counts[blk] != '1) trk_counts[blk] = trk_counts[blk] + 1'b1;
    end else begin
      if (trk_drops != '1) trk_drops = trk_drops + 1'b1;
    end
    rep.missed_total = trk_missed;
    rep.drop_count = trk_drops;
  endtask

  function automatic bwt_pkg::result_t plain_report(input logic acc,
                                                    input logic [bwt_pkg::OBLK_W-1:0] blk,
                                                    input logic [bwt_pkg::OSLOT_W-1:0] slot,
                                                    input logic first,
                                                    input logic [bwt_pkg::DROP_W-1:0] drops);
    bwt_pkg::result_t rep;
    rep = '0;
    rep.accepted = acc;
    rep.block_index = blk;
    rep.baseline_slot = slot;
    rep.first_in_slot = first;
    rep.drop_count = drops;
    return rep;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (tx_quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // header count relative to the current window
  function automatic logic [bwt_pkg::BCNT_W-1:0] pick_bcnt(input int unsigned retire_pct);
    int unsigned r;
    logic [bwt_pkg::BCNT_W-1:0] span;
    r = $urandom_range(99);
    if (r < retire_pct) begin
      span = $urandom_range(3 * bwt_pkg::BASELINES - 1, 2 * bwt_pkg::BASELINES);
    end else begin
      r = $urandom_range(99);
      if (r < 65) begin
        span = $urandom_range(2 * bwt_pkg::BASELINES - 1, 0);
      end else if (r < 75) begin
        case ($urandom_range(5))
          0: span = 2 * bwt_pkg::BASELINES - 1;
          1: span = 2 * bwt_pkg::BASELINES;
          2: span = 3 * bwt_pkg::BASELINES - 1;
          3: span = 3 * bwt_pkg::BASELINES;
          4: span = '1;
          default: span = '0;
        endcase
      end else begin
        span = $urandom;
      end
    end
    return trk_start + span;
  endfunction

  // offer one header beat, wait for it to be taken, log the expected report
  task automatic send_beat(input logic [bwt_pkg::BCNT_W-1:0] bcnt, input int gap,
                           input bit typed, input bwt_pkg::result_t typed_res);
    bwt_pkg::result_t want;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_bcnt <= bcnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_window(bcnt, want);
    pending_reports.push_back(typed ? typed_res : want);
  endtask

  // register write once the block has drained
  task automatic write_expected(input logic [bwt_pkg::CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_expected_packets <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_expected = value;
  endtask

  task automatic run_phase(input int n, input int unsigned retire_pct, input bit hold);
    int i;
    int gap;
    for (i = 0; i < n; i++) begin
      // long receiver hold while headers keep coming back to back
      if (hold && i == n / 3) rx_hold_req = 1'b1;
      gap = (hold && i >= n / 3 && i < n / 3 + 60) ? 0 : pick_gap();
      send_beat(pick_bcnt(retire_pct), gap, 1'b0, '0);
    end
  endtask

  // receiver stall pattern
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !rx_quiet) begin
        case ($urandom_range(99))
          0: stall_left = $urandom_range(80, 20);
          1, 2, 3, 4, 5, 6, 7, 8, 9: stall_left = $urandom_range(4, 1);
          default: stall_left = 0;
        endcase
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin : report_check
    bwt_pkg::result_t got;
    bwt_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.accepted = out_accepted;
      got.block_index = out_block_index;
      got.baseline_slot = out_baseline_slot;
      got.first_in_slot = out_first_in_slot;
      got.block_filled = out_block_filled;
      got.filled_block_index = out_filled_block_index;
      got.filled_start_count = out_filled_start_count;
      got.filled_missed = out_filled_missed;
      got.missed_total = out_missed_total;
      got.drop_count = out_drop_count;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
      end else begin
        want = pending_reports.pop_front();
        note_field("accepted", want.accepted, got.accepted);
        note_field("block_index", want.block_index, got.block_index);
        note_field("baseline_slot", want.baseline_slot, got.baseline_slot);
        note_field("first_in_slot", want.first_in_slot, got.first_in_slot);
        note_field("block_filled", want.block_filled, got.block_filled);
        note_field("filled_block_index", want.filled_block_index, got.filled_block_index);
        note_field("filled_start_count", want.filled_start_count, got.filled_start_count);
        note_field("filled_missed", want.filled_missed, got.filled_missed);
        note_field("missed_total", want.missed_total, got.missed_total);
        note_field("drop_count", want.drop_count, got.drop_count);
      end
    end
  end

  // stimulus
  initial begin
    int i;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_packet_bcnt <= '0;
    cfg_valid <= 1'b0;
    cfg_expected_packets <= '0;

    // unaligned first header just below the wrap, then window edges and far misses
    opening_rows = '{
      '{32'hFFFF_FF80, 1'b1, plain_report(1'b1, 2'd3, 8'h80, 1'b1, 16'd0)},
      '{32'hFFFF_FF80, 1'b1, plain_report(1'b1, 2'd3, 8'h80, 1'b0, 16'd0)},
      '{32'hFFFF_FFFF, 1'b1, plain_report(1'b1, 2'd3, 8'hFF, 1'b1, 16'd0)},
      '{32'h0000_0000, 1'b1, plain_report(1'b1, 2'd0, 8'h00, 1'b1, 16'd0)},
      '{32'h0000_017F, 1'b1, plain_report(1'b1, 2'd1, 8'h7F, 1'b1, 16'd0)},
      '{32'h0000_0280, 1'b1, plain_report(1'b0, 2'd2, 8'h80, 1'b0, 16'd1)},
      '{32'hFFFF_FF7F, 1'b1, plain_report(1'b0, 2'd3, 8'h7F, 1'b0, 16'd2)},
      '{32'h7FFF_FFFF, 1'b1, plain_report(1'b0, 2'd3, 8'hFF, 1'b0, 16'd3)},
      '{32'h0000_027F, 1'b0, '0},
      '{32'h0000_0280, 1'b0, '0},
      '{32'h0000_0480, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'h0000_047F, 1'b0, '0},
      '{32'h0000_0000, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h0000_057F, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening with the reset value of expected_packets
    for (i = 0; i < $size(opening_rows); i++)
      send_beat(opening_rows[i].bcnt, pick_gap(), opening_rows[i].typed, opening_rows[i].res);

    // smallest nonzero expected count: most blocks overfilled
    write_expected(24'd1);
    run_phase(100, 10, 1'b0);

    // small expected count, receiver held off to back the block up
    write_expected(bwt_pkg::CNT_W'($urandom_range(300, 2)));
    run_phase(120, 15, 1'b1);

    // zero expected: nothing ever missed
    write_expected('0);
    run_phase(100, 15, 1'b0);

    // largest expected count with fast retirement, drives the missed total into saturation
    write_expected('1);
    run_phase(350, 85, 1'b0);

    write_expected(bwt_pkg::CNT_W'($urandom_range(24'hFF_FFFF, 1)));
    run_phase(100, 15, 1'b0);

    // back-to-back run of out-of-window headers
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (i = 0; i < DROP_BURST; i++)
      send_beat(trk_start + bwt_pkg::BCNT_W'($urandom_range(32'hFFFF_FFFF,
                                                           3 * bwt_pkg::BASELINES)),
                0, 1'b0, '0);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    write_expected(bwt_pkg::EXPECTED_RESET);
    run_phase(40, 20, 1'b0);

    // drain and settle
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("packet_block_window_tracker_core_tb passed");
    end else begin
      $display("packet_block_window_tracker_core_tb failed");
    end
    $finish;
  end

endmodule

[packet_block_window_tracker_core.f]
design/bwt_pkg.sv
design/bwt_slot_tags.sv
design/bwt_window.sv
design/packet_block_window_tracker_core.sv
verif/packet_block_window_tracker_core_tb.sv
